/* hdl/hmtok_pkg.sv */
// ----------------------------------------------------------------------------
// hmtok_pkg
// shared types and constants of the heightmap line tokenizer
// ----------------------------------------------------------------------------
package hmtok_pkg;

    // default parameter values
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 4096;

    // fixed field widths
    localparam int ROW_W    = 12;
    localparam int COLUMN_W = 10;
    localparam int HEIGHT_W = 16;
    localparam int COLOR_W  = 24;

    // characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    // characters swallowed after the comma ("0x")
    localparam logic [1:0] PREFIX_LEN = 2'd2;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_PREFIX = 2'd2,
        PH_HEX    = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [1:0]           prefix_left;
        logic                 color_seen;
        logic [COLOR_W-1:0]   color_acc;
    } t_tok_ctl;

    localparam t_tok_ctl TOK_CTL_CLEAR = '{
        phase:       PH_SKIP,
        prefix_left: 2'd0,
        color_seen:  1'b0,
        color_acc:   '0
    };

endpackage

/* hdl/hmtok_step.sv */
// ----------------------------------------------------------------------------
// hmtok_step
// per-character token update: phase, height, color suffix
// ----------------------------------------------------------------------------
module hmtok_step #(
    parameter int HEIGHT_BITS = hmtok_pkg::HEIGHT_BITS_DEF
) (
    input  hmtok_pkg::t_tok_ctl     i_ctl,
    input  logic [HEIGHT_BITS-1:0]  i_height,
    input  logic [7:0]              i_char,
    input  logic                    i_last,
    output hmtok_pkg::t_tok_ctl     o_upd,
    output logic [HEIGHT_BITS-1:0]  o_upd_height,
    output logic                    o_token_end
);

    logic                    is_digit;
    logic                    is_space;
    logic                    is_comma;
    logic                    is_hex;
    logic [3:0]              hex_val;
    logic [3:0]              dig_val;
    logic [1:0]              prefix_dec;
    logic [HEIGHT_BITS+3:0]  height_x10;
    logic                    height_sat;
    hmtok_pkg::t_phase       upd_phase;

    always_comb begin
        is_digit = (i_char >= hmtok_pkg::CH_ZERO) && (i_char <= hmtok_pkg::CH_NINE);
        is_space = (i_char == hmtok_pkg::CH_SPACE);
        is_comma = (i_char == hmtok_pkg::CH_COMMA);
        dig_val  = 4'(i_char - hmtok_pkg::CH_ZERO);
        is_hex   = 1'b1;
        hex_val  = dig_val;
        priority if (is_digit) begin
            hex_val = dig_val;
        end else if ((i_char >= hmtok_pkg::CH_LO_A) && (i_char <= hmtok_pkg::CH_LO_F)) begin
            hex_val = 4'(i_char - hmtok_pkg::CH_LO_A + 8'd10);
        end else if ((i_char >= hmtok_pkg::CH_UP_A) && (i_char <= hmtok_pkg::CH_UP_F)) begin
            hex_val = 4'(i_char - hmtok_pkg::CH_UP_A + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign prefix_dec = i_ctl.prefix_left - 2'd1;

    // acc * 10 + digit as shift-add, saturating at the height width
    assign height_x10 = ({4'd0, i_height} << 3) + ({4'd0, i_height} << 1)
                        + (HEIGHT_BITS + 4)'(dig_val);
    assign height_sat = |height_x10[HEIGHT_BITS+3:HEIGHT_BITS];

    // next phase
    always_comb begin
        upd_phase = i_ctl.phase;
        unique case (i_ctl.phase)
            hmtok_pkg::PH_SKIP: begin
                if (is_digit) upd_phase = hmtok_pkg::PH_DIGITS;
            end
            hmtok_pkg::PH_DIGITS: begin
                if (is_comma) upd_phase = hmtok_pkg::PH_PREFIX;
            end
            hmtok_pkg::PH_PREFIX: begin
                if (!is_space && (prefix_dec == 2'd0)) upd_phase = hmtok_pkg::PH_HEX;
            end
            hmtok_pkg::PH_HEX: begin
                upd_phase = hmtok_pkg::PH_HEX;
            end
            default: begin
                upd_phase = hmtok_pkg::PH_SKIP;
            end
        endcase
    end

    // datapath and token end
    always_comb begin
        o_upd        = i_ctl;
        o_upd.phase  = upd_phase;
        o_upd_height = i_height;
        unique case (i_ctl.phase)
            hmtok_pkg::PH_SKIP: begin
                if (is_digit) o_upd_height = HEIGHT_BITS'(dig_val);
            end
            hmtok_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    o_upd_height = height_sat ? {HEIGHT_BITS{1'b1}}
                                              : height_x10[HEIGHT_BITS-1:0];
                end else if (is_comma) begin
                    o_upd.color_seen  = 1'b1;
                    o_upd.color_acc   = '0;
                    o_upd.prefix_left = hmtok_pkg::PREFIX_LEN;
                end
            end
            hmtok_pkg::PH_PREFIX: begin
                if (!is_space) o_upd.prefix_left = prefix_dec;
            end
            hmtok_pkg::PH_HEX: begin
                if (!is_space && is_hex) begin
                    o_upd.color_acc = {i_ctl.color_acc[hmtok_pkg::COLOR_W-5:0], hex_val};
                end
            end
            default: begin
                o_upd = i_ctl;
            end
        endcase
        // a space closes an open token; line end closes whatever is open after the update
        o_token_end = ((i_ctl.phase != hmtok_pkg::PH_SKIP) && is_space)
                      || (i_last && (upd_phase != hmtok_pkg::PH_SKIP));
    end

endmodule

/* hdl/heightmap_line_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// heightmap_line_tokenizer_core: one character per cycle, one item per cycle sustained while entries are taken
// path: a closing character is loaded into the input register when accepted, and its
// entry is loaded into the result register when stage 1 moves on
// stalls: an entry left waiting holds stage 1, then o_ready falls until it is taken
// reset: synchronous active-low, clears the token, column count and both stages
// ----------------------------------------------------------------------------
//
// decimal height tokens with an optional ",0x" hex color suffix
//  - input register holds one character, line-end flag and row
//  - hmtok_step computes the token update from that register and the state
//  - an entry goes to the result register when a token ends (space or line end) within the column and row limits
//  - the input register advances whenever the result register is free or
//    being drained; a waiting entry holds it, and the character side stalls
//    once the input register is full as well
module heightmap_line_tokenizer_core #(
    parameter int MAX_COLUMNS = hmtok_pkg::MAX_COLUMNS_DEF,
    parameter int HEIGHT_BITS = hmtok_pkg::HEIGHT_BITS_DEF,
    parameter int MAX_ROWS    = hmtok_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // character channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_char_byte,
    input  logic                              i_line_end,
    input  logic [hmtok_pkg::ROW_W-1:0]       i_row_index,
    // entry channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hmtok_pkg::ROW_W-1:0]       o_row,
    output logic [hmtok_pkg::COLUMN_W-1:0]    o_column,
    output logic [hmtok_pkg::HEIGHT_W-1:0]    o_height,
    output logic [hmtok_pkg::COLOR_W-1:0]     o_color,
    output logic                              o_color_valid,
    output logic                              o_end_of_row
);

    // column counter must be able to hold MAX_COLUMNS itself
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);

    // input register
    logic                           r_s1_valid;
    logic [7:0]                     r_s1_char;
    logic                           r_s1_last;
    logic [hmtok_pkg::ROW_W-1:0]    r_s1_row;

    // token state
    hmtok_pkg::t_tok_ctl            r_ctl,    n_ctl;
    logic [HEIGHT_BITS-1:0]         r_height, n_height;
    logic [COL_W-1:0]               r_col,    n_col;

    // result register
    logic                           r_out_valid;
    logic [hmtok_pkg::ROW_W-1:0]    r_out_row;
    logic [hmtok_pkg::COLUMN_W-1:0] r_out_column;
    logic [hmtok_pkg::HEIGHT_W-1:0] r_out_height;
    logic [hmtok_pkg::COLOR_W-1:0]  r_out_color;
    logic                           r_out_color_valid;
    logic                           r_out_eor;

    // step outputs
    hmtok_pkg::t_tok_ctl            upd_ctl;
    logic [HEIGHT_BITS-1:0]         upd_height;
    logic                           token_end;

    logic                           s1_go;
    logic                           col_room;
    logic                           row_ok;
    logic                           emit_ok;
    logic [31:0]                    col_ext;
    logic [31:0]                    height_ext;

    // stage 1 moves on when the result register can take whatever it produces
    assign s1_go   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_char <= i_char_byte;
            r_s1_last <= i_line_end;
            r_s1_row  <= i_row_index;
        end
    end

    hmtok_step #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_step (
        .i_ctl        (r_ctl),
        .i_height     (r_height),
        .i_char       (r_s1_char),
        .i_last       (r_s1_last),
        .o_upd        (upd_ctl),
        .o_upd_height (upd_height),
        .o_token_end  (token_end)
    );

    // entries past the column limit are dropped and the count holds;
    // out-of-range rows are dropped but still use up a column
    assign col_room = 32'(r_col) < 32'(MAX_COLUMNS);
    assign row_ok   = 32'(r_s1_row) < 32'(MAX_ROWS);
    assign emit_ok  = token_end && col_room && row_ok;

    always_comb begin
        n_ctl    = upd_ctl;
        n_height = upd_height;
        n_col    = r_col;
        if (token_end || r_s1_last) begin
            n_ctl    = hmtok_pkg::TOK_CTL_CLEAR;
            n_height = '0;
        end
        if (token_end && col_room) begin
            n_col = r_col + COL_W'(1);
        end
        // line end restarts the column count
        if (r_s1_last) begin
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= hmtok_pkg::TOK_CTL_CLEAR;
            r_height <= '0;
            r_col    <= '0;
        end else if (s1_go) begin
            r_ctl    <= n_ctl;
            r_height <= n_height;
            r_col    <= n_col;
        end
    end

    // zero-extend before trimming to the port widths
    assign col_ext    = 32'(r_col);
    assign height_ext = 32'(upd_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= emit_ok;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && emit_ok) begin
            r_out_row         <= r_s1_row;
            r_out_column      <= col_ext[hmtok_pkg::COLUMN_W-1:0];
            r_out_height      <= height_ext[hmtok_pkg::HEIGHT_W-1:0];
            r_out_color       <= upd_ctl.color_acc;
            r_out_color_valid <= upd_ctl.color_seen;
            r_out_eor         <= r_s1_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_row         = r_out_row;
    assign o_column      = r_out_column;
    assign o_height      = r_out_height;
    assign o_color       = r_out_color;
    assign o_color_valid = r_out_color_valid;
    assign o_end_of_row  = r_out_eor;

`ifndef SYNTH
    // column count never runs past its limit
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) <= 32'(MAX_COLUMNS))
        else $error("column count beyond limit");

    // while skipping, no token data is left over
    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.phase == hmtok_pkg::PH_SKIP) |-> ((r_height == '0) && !r_ctl.color_seen))
        else $error("stale token data while skipping");

    // color bits only build up after a comma
    a_color_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ctl.color_seen |-> (r_ctl.color_acc == '0))
        else $error("color accumulated without suffix");

    // a processed line end restarts the column count
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_last) |=> (r_col == '0))
        else $error("column count not cleared at line end");
`endif

endmodule

/* tb/hmtok_entry_checker.sv */
// ----------------------------------------------------------------------------
// hmtok_entry_checker
// watches the character and entry channels of the heightmap line tokenizer,
// predicts every entry from the accepted characters and compares in order
// ----------------------------------------------------------------------------
module hmtok_entry_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // character channel
    input  logic                           i_char_valid,
    input  logic                           i_char_ready,
    input  logic [7:0]                     i_char_byte,
    input  logic                           i_line_end,
    input  logic [hmtok_pkg::ROW_W-1:0]    i_row_index,
    // entry channel
    input  logic                           i_entry_valid,
    input  logic                           i_entry_ready,
    input  logic [hmtok_pkg::ROW_W-1:0]    i_row,
    input  logic [hmtok_pkg::COLUMN_W-1:0] i_column,
    input  logic [hmtok_pkg::HEIGHT_W-1:0] i_height,
    input  logic [hmtok_pkg::COLOR_W-1:0]  i_color,
    input  logic                           i_color_valid,
    input  logic                           i_end_of_row,
    // status for the top
    output int                             o_mismatches,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned HEIGHT_MAX = (64'd1 << hmtok_pkg::HEIGHT_BITS_DEF) - 64'd1;

    typedef struct packed {
        logic [hmtok_pkg::ROW_W-1:0]    row;
        logic [hmtok_pkg::COLUMN_W-1:0] column;
        logic [hmtok_pkg::HEIGHT_W-1:0] height;
        logic [hmtok_pkg::COLOR_W-1:0]  color;
        logic                           color_valid;
        logic                           end_of_row;
    } t_map_entry;

    // token state of the predictor
    hmtok_pkg::t_phase              tok_phase;
    logic [1:0]                     prefix_left;
    longint unsigned                height_acc;
    logic [hmtok_pkg::COLOR_W-1:0]  color_acc;
    logic                           color_seen;
    int unsigned                    column_count;

    t_map_entry                     expected_entries[$];
    t_map_entry                     head;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        o_mismatches++;
        $display("[%0t] entry %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic clear_token();
        tok_phase   = hmtok_pkg::PH_SKIP;
        prefix_left = 2'd0;
        height_acc  = 64'd0;
        color_acc   = '0;
        color_seen  = 1'b0;
    endtask

    // token finished: queue an entry unless the line is full or the row is out of range
    task automatic close_token(input logic [hmtok_pkg::ROW_W-1:0] row, input logic eor);
        t_map_entry e;
        if (column_count < hmtok_pkg::MAX_COLUMNS_DEF) begin
            if (row < hmtok_pkg::MAX_ROWS_DEF) begin
                e.row         = row;
                e.column      = column_count[hmtok_pkg::COLUMN_W-1:0];
                e.height      = height_acc[hmtok_pkg::HEIGHT_W-1:0];
                e.color       = color_acc;
                e.color_valid = color_seen;
                e.end_of_row  = eor;
                expected_entries.push_back(e);
            end
            column_count++;
        end
        clear_token();
    endtask

    task automatic tokenize_char(input logic [7:0] ch, input logic last,
                                 input logic [hmtok_pkg::ROW_W-1:0] row);
        logic            closed;
        logic            is_digit;
        logic            is_hex;
        logic [3:0]      nib;
        longint unsigned grown;
        closed   = 1'b0;
        is_digit = (ch >= hmtok_pkg::CH_ZERO) && (ch <= hmtok_pkg::CH_NINE);
        case (tok_phase)
            hmtok_pkg::PH_SKIP: begin
                if (is_digit) begin
                    height_acc = 64'(ch - hmtok_pkg::CH_ZERO);
                    tok_phase  = hmtok_pkg::PH_DIGITS;
                end
            end
            hmtok_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    grown      = height_acc * 64'd10 + 64'(ch - hmtok_pkg::CH_ZERO);
                    height_acc = (grown > HEIGHT_MAX) ? HEIGHT_MAX : grown;
                end else if (ch == hmtok_pkg::CH_SPACE) begin
                    close_token(row, last);
                    closed = 1'b1;
                end else if (ch == hmtok_pkg::CH_COMMA) begin
                    color_seen  = 1'b1;
                    color_acc   = '0;
                    prefix_left = hmtok_pkg::PREFIX_LEN;
                    tok_phase   = hmtok_pkg::PH_PREFIX;
                end
            end
            hmtok_pkg::PH_PREFIX: begin
                if (ch == hmtok_pkg::CH_SPACE) begin
                    close_token(row, last);
                    closed = 1'b1;
                end else begin
                    prefix_left = prefix_left - 2'd1;
                    if (prefix_left == 2'd0)
                        tok_phase = hmtok_pkg::PH_HEX;
                end
            end
            default: begin
                if (ch == hmtok_pkg::CH_SPACE) begin
                    close_token(row, last);
                    closed = 1'b1;
                end else begin
                    is_hex = 1'b1;
                    nib    = 4'd0;
                    if (is_digit)
                        nib = 4'(ch - hmtok_pkg::CH_ZERO);
                    else if (ch >= hmtok_pkg::CH_LO_A && ch <= hmtok_pkg::CH_LO_F)
                        nib = 4'(ch - hmtok_pkg::CH_LO_A + 8'd10);
                    else if (ch >= hmtok_pkg::CH_UP_A && ch <= hmtok_pkg::CH_UP_F)
                        nib = 4'(ch - hmtok_pkg::CH_UP_A + 8'd10);
                    else
                        is_hex = 1'b0;
                    if (is_hex)
                        color_acc = {color_acc[hmtok_pkg::COLOR_W-5:0], nib};
                end
            end
        endcase
        if (last) begin
            if (!closed && tok_phase != hmtok_pkg::PH_SKIP)
                close_token(row, 1'b1);
            clear_token();
            column_count = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_token();
            column_count = 0;
            expected_entries.delete();
            o_mismatches = 0;
        end else begin
            if (i_char_valid && i_char_ready)
                tokenize_char(i_char_byte, i_line_end, i_row_index);
            if (i_entry_valid && i_entry_ready) begin
                if (expected_entries.size() == 0) begin
                    report_mismatch("with nothing pending, column", i_column, 0);
                end else begin
                    head = expected_entries.pop_front();
                    if (i_row !== head.row)
                        report_mismatch("row", i_row, head.row);
                    if (i_column !== head.column)
                        report_mismatch("column", i_column, head.column);
                    if (i_height !== head.height)
                        report_mismatch("height", i_height, head.height);
                    if (i_color !== head.color)
                        report_mismatch("color", i_color, head.color);
                    if (i_color_valid !== head.color_valid)
                        report_mismatch("color_valid", i_color_valid, head.color_valid);
                    if (i_end_of_row !== head.end_of_row)
                        report_mismatch("end_of_row", i_end_of_row, head.end_of_row);
                end
            end
        end
        o_pending = expected_entries.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// regression for heightmap_line_tokenizer_core: directed lines and random text
// lines under changing backpressure, checked entry by entry by
// hmtok_entry_checker
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int CYCLE_LIMIT   = 200000;
    // second character of the color prefix
    localparam logic [7:0] CH_LO_X = 8'h78;

    logic                           clk;
    logic                           rst_n       = 1'b0;
    // character channel, driven here
    logic                           char_valid  = 1'b0;
    logic                           char_ready;
    logic [7:0]                     char_byte   = 8'd0;
    logic                           line_end    = 1'b0;
    logic [hmtok_pkg::ROW_W-1:0]    row_index   = '0;
    // entry channel, drained here
    logic                           entry_valid;
    logic                           entry_ready = 1'b0;
    logic [hmtok_pkg::ROW_W-1:0]    ent_row;
    logic [hmtok_pkg::COLUMN_W-1:0] ent_column;
    logic [hmtok_pkg::HEIGHT_W-1:0] ent_height;
    logic [hmtok_pkg::COLOR_W-1:0]  ent_color;
    logic                           ent_color_valid;
    logic                           ent_end_of_row;

    int                             mismatches;
    int                             pending;

    // idle odds in percent for each side, changed between phases
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    // asks the entry sink for one long hold-off
    bit                             stall_go      = 1'b0;
    // characters of the line being built
    logic [7:0]                     line_buf[$];

    heightmap_line_tokenizer_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (char_valid),
        .o_ready       (char_ready),
        .i_char_byte   (char_byte),
        .i_line_end    (line_end),
        .i_row_index   (row_index),
        .o_valid       (entry_valid),
        .i_ready       (entry_ready),
        .o_row         (ent_row),
        .o_column      (ent_column),
        .o_height      (ent_height),
        .o_color       (ent_color),
        .o_color_valid (ent_color_valid),
        .o_end_of_row  (ent_end_of_row)
    );

    hmtok_entry_checker entry_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_char_valid  (char_valid),
        .i_char_ready  (char_ready),
        .i_char_byte   (char_byte),
        .i_line_end    (line_end),
        .i_row_index   (row_index),
        .i_entry_valid (entry_valid),
        .i_entry_ready (entry_ready),
        .i_row         (ent_row),
        .i_column      (ent_column),
        .i_height      (ent_height),
        .i_color       (ent_color),
        .i_color_valid (ent_color_valid),
        .i_end_of_row  (ent_end_of_row),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d entries outstanding", CYCLE_LIMIT, pending);
        $display("heightmap_line_tokenizer_core regression: fail");
        $finish;
    end

    // entry sink: random ready, plus one long hold-off on request so the
    // result register stays full and the character side has to stall
    initial begin : entry_sink
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_go && !stall_done) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                entry_ready <= 1'b0;
                stall_left--;
            end else begin
                entry_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one character and hold it until the block takes it;
    // random gaps with valid low come first
    task automatic send_char(input logic [7:0] ch, input logic last,
                             input logic [hmtok_pkg::ROW_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_byte  <= ch;
        line_end   <= last;
        row_index  <= row;
        do @(posedge clk); while (!char_ready);
    endtask

    // the last character of the buffer carries the line end
    task automatic send_line(input logic [hmtok_pkg::ROW_W-1:0] row);
        foreach (line_buf[k])
            send_char(line_buf[k], k == line_buf.size() - 1, row);
        line_buf.delete();
    endtask

    task automatic send_text(input string s, input logic [hmtok_pkg::ROW_W-1:0] row);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
        send_line(row);
    endtask

    // junk character: never a digit or space; in a color also never a hex
    // letter, in a height never a comma
    function automatic logic [7:0] stray_char(input bit in_color);
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == hmtok_pkg::CH_SPACE ||
               (c >= hmtok_pkg::CH_ZERO && c <= hmtok_pkg::CH_NINE) ||
               (!in_color && c == hmtok_pkg::CH_COMMA) ||
               (in_color && ((c >= hmtok_pkg::CH_LO_A && c <= hmtok_pkg::CH_LO_F) ||
                             (c >= hmtok_pkg::CH_UP_A && c <= hmtok_pkg::CH_UP_F))));
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return hmtok_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(1) ? hmtok_pkg::CH_UP_A : hmtok_pkg::CH_LO_A) + 8'(v - 10);
    endfunction

    // one height token, mostly short, sometimes long enough to saturate,
    // often with a color suffix
    task automatic add_token();
        int digits;
        int hexes;
        digits = ($urandom_range(7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        for (int k = 0; k < digits; k++) begin
            line_buf.push_back(hmtok_pkg::CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(24) == 0)
                line_buf.push_back(stray_char(1'b0));
        end
        if ($urandom_range(2) == 0)
            return;
        line_buf.push_back(hmtok_pkg::CH_COMMA);
        case ($urandom_range(9))
            0: begin
                // token ends right after the comma
                line_buf.push_back(hmtok_pkg::CH_SPACE);
                return;
            end
            1: begin
                // token ends inside the prefix
                line_buf.push_back(stray_char(1'b1));
                line_buf.push_back(hmtok_pkg::CH_SPACE);
                return;
            end
            2: begin
                // prefix is whatever comes, not "0x"
                line_buf.push_back(hex_char());
                line_buf.push_back(stray_char(1'b1));
            end
            default: begin
                line_buf.push_back(hmtok_pkg::CH_ZERO);
                line_buf.push_back(CH_LO_X);
            end
        endcase
        hexes = $urandom_range(8);
        for (int k = 0; k < hexes; k++) begin
            line_buf.push_back(hex_char());
            if ($urandom_range(19) == 0)
                line_buf.push_back(stray_char(1'b1));
        end
    endtask

    // mostly well-formed lines of tokens; some lines are raw bytes
    task automatic build_random_line();
        int tokens;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12))
                line_buf.push_back(8'($urandom_range(255)));
            return;
        end
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            if (t > 0 || $urandom_range(1)) begin
                repeat ($urandom_range(1, 2))
                    line_buf.push_back(($urandom_range(4) == 0) ? stray_char(1'b0)
                                                               : hmtok_pkg::CH_SPACE);
            end
            add_token();
        end
        // end on the token itself, on a space, or on a stray character inside the last token
        case ($urandom_range(2))
            0: ;
            1: line_buf.push_back(hmtok_pkg::CH_SPACE);
            default: line_buf.push_back(stray_char(1'b0));
        endcase
    endtask

    task automatic random_lines(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            build_random_line();
            sent += line_buf.size();
            send_line(12'($urandom));
        end
    endtask

    initial begin : stimulus
        int drain_wait;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 46;

        // zero height, stray letter in a height, space inside the prefix at line end
        send_text("0 7z1,0 ", 12'd0);
        // saturated height, mixed-case hex, stray in the color, seven hex digits,
        // token closed by the line end on the top row
        send_text("99999,0xFfFfFfg1", 12'hFFF);
        // line that ends while skipping
        send_text("#", 12'd5);

        random_lines(RANDOM_ITEMS / 3);

        send_idle_pct = 46;
        recv_idle_pct = 9;
        random_lines(RANDOM_ITEMS / 3);

        // no idling; the sink holds off for a long stretch at the start
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_go      = 1'b1;
        random_lines(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        char_valid <= 1'b0;

        // all characters are in; let the last entries drain
        repeat (4) @(posedge clk);
        drain_wait = 0;
        while (pending != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("heightmap_line_tokenizer_core regression: pass");
        end else begin
            if (pending != 0)
                $display("%0d expected entries never arrived", pending);
            $display("heightmap_line_tokenizer_core regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/hmtok_pkg.sv
hdl/hmtok_step.sv
hdl/heightmap_line_tokenizer_core.sv
tb/hmtok_entry_checker.sv
tb/tb.sv
